[rtl/phtmc_pkg.sv]
// Shared types and constants for the pH trimmed-mean conditioner.
package phtmc_pkg;

    localparam int SMP_W       = 10;
    localparam int SMP_MAX     = 1023;
    localparam int PH_W        = 11;
    localparam int OFS_W       = 12;
    localparam int SLOPE_W     = 16;
    localparam int LIM_W       = 11;
    localparam int ERR_W       = 3;
    localparam int Q_FRAC      = 16;
    localparam int Q_HALF      = 32768;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    // Output word layout
    localparam int OUT_PH_LSB  = 0;
    localparam int OUT_OK_BIT  = PH_W;
    localparam int OUT_ERR_LSB = PH_W + 1;

    localparam logic [ERR_W-1:0]   FAULT_MAX       = 3'd7;
    localparam logic [OFS_W-1:0]   RST_PH_OFFSET   = 12'd2540;
    localparam logic [SLOPE_W-1:0] RST_PH_SLOPE    = 16'd12627;
    localparam logic [LIM_W-1:0]   RST_LOW_LIMIT   = 11'd360;
    localparam logic [LIM_W-1:0]   RST_HIGH_LIMIT  = 11'd1100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PH_OFFSET  = 2'd0,
        CFG_PH_SLOPE   = 2'd1,
        CFG_LOW_LIMIT  = 2'd2,
        CFG_HIGH_LIMIT = 2'd3
    } t_cfg_idx;

endpackage

[rtl/ph_trimmed_mean_conditioner.sv]
// pH trimmed-mean conditioner: per-probe batch trimming, conversion and averaging.
// Throughput: one sample word per cycle unless the last sample of a batch waits;
// a result is emitted once per batch. A batch's result passes through the batch
// register, slope product, blend numerator and output register, in that order.
// The last sample of a batch waits only while the batch register holds an earlier batch.
// Reset (synchronous, active low) clears counters, averages, reports and fault counts
// and loads the register defaults at once.
module ph_trimmed_mean_conditioner #(
    parameter int GROUPS            = 4,
    parameter int SAMPLES_PER_GROUP = 5,
    parameter int AVERAGE_WEIGHT    = 20,
    parameter int ERROR_LIMIT       = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [phtmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [phtmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [phtmc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [9:0] sample
    input  logic                                 s_axis_tuser,  // [0] probe
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [phtmc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [10:0] ph_reported,
                                                                // [11] in_range,
                                                                // [14:12] error_count
    output logic                                 m_axis_tuser   // [0] probe_id
);

    localparam int SMP_W   = phtmc_pkg::SMP_W;
    localparam int PH_W    = phtmc_pkg::PH_W;
    localparam int OFS_W   = phtmc_pkg::OFS_W;
    localparam int SLOPE_W = phtmc_pkg::SLOPE_W;
    localparam int LIM_W   = phtmc_pkg::LIM_W;
    localparam int ERR_W   = phtmc_pkg::ERR_W;

    localparam int SIDX_W  = $clog2(SAMPLES_PER_GROUP);
    localparam int GIDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SUM_MAX = ((GROUPS - 1) * (SAMPLES_PER_GROUP - 2) + SAMPLES_PER_GROUP)
                             * phtmc_pkg::SMP_MAX;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int PROD_W  = SUM_W + SLOPE_W + 1;
    localparam int TERM_W  = PROD_W - phtmc_pkg::Q_FRAC;
    localparam int AVG_L   = $clog2(AVERAGE_WEIGHT);
    localparam int NUM_W   = PH_W + AVG_L;
    localparam int RECIP_K = NUM_W + AVG_L;
    localparam int RECIP_W = NUM_W + 1;
    localparam int QPROD_W = NUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_K) + 64'(AVERAGE_WEIGHT) - 64'd1) / 64'(AVERAGE_WEIGHT);

    // configuration
    logic [OFS_W-1:0]   r_ofs;
    logic [SLOPE_W-1:0] r_slope;
    logic [LIM_W-1:0]   r_low;
    logic [LIM_W-1:0]   r_high;

    // sample accumulation
    logic [SIDX_W-1:0]  r_sidx;
    logic [GIDX_W-1:0]  r_gidx;
    logic [SMP_W-1:0]   r_lo;
    logic [SMP_W-1:0]   r_hi;
    logic [SUM_W-1:0]   r_sum;

    // batch-end pipeline
    logic               r_fin_valid;
    logic [SUM_W-1:0]   r_fin_sum;
    logic               r_fin_probe;
    logic               r_p1_valid;
    logic [TERM_W-1:0]  r_p1_term;
    logic               r_p1_probe;
    logic               r_p2_valid;
    logic [NUM_W-1:0]   r_p2_num;
    logic [PH_W-1:0]    r_p2_val;
    logic               r_p2_ok;
    logic               r_p2_avgnz;
    logic               r_p2_probe;

    // per-probe state
    logic [PH_W-1:0]    r_avg [2];
    logic [PH_W-1:0]    r_rep [2];
    logic [ERR_W-1:0]   r_fc  [2];

    // output register
    logic               r_o_valid;
    logic               r_o_probe;
    logic [PH_W-1:0]    r_o_ph;
    logic               r_o_ok;
    logic [ERR_W-1:0]   r_o_err;

    logic [SMP_W-1:0]   smp;
    logic               first_smp;
    logic               grp_last;
    logic               batch_last;
    logic [SMP_W-1:0]   n_lo;
    logic [SMP_W-1:0]   n_hi;
    logic [SUM_W-1:0]   sum_acc;
    logic [SUM_W-1:0]   sum_trim;
    logic               accept;
    logic               load_fin;
    logic               load_p1;
    logic               load_p2;
    logic               p2_moves;
    logic [PROD_W-1:0]  prod;
    logic [OFS_W-1:0]   value;
    logic               term_ok;
    logic               val_ok;
    logic [PH_W-1:0]    avg_rd;
    logic [NUM_W-1:0]   num;
    logic [QPROD_W-1:0] qprod;
    logic [PH_W-1:0]    quo;
    logic [PH_W-1:0]    new_val;
    logic [ERR_W-1:0]   fc_rd;
    logic [ERR_W-1:0]   fc_inc;
    logic [PH_W-1:0]    rep_bad;

    // sample path
    always_comb begin
        smp        = s_axis_tdata[SMP_W-1:0];
        first_smp  = (r_sidx == '0);
        grp_last   = (r_sidx == SIDX_W'(SAMPLES_PER_GROUP - 1));
        batch_last = grp_last && (r_gidx == GIDX_W'(GROUPS - 1));
        n_lo       = (first_smp || (smp < r_lo)) ? smp : r_lo;
        n_hi       = (first_smp || (smp > r_hi)) ? smp : r_hi;
        sum_acc    = r_sum + SUM_W'(smp);
        sum_trim   = sum_acc - SUM_W'(n_lo) - SUM_W'(n_hi);
    end

    // pipeline flow
    always_comb begin
        p2_moves      = !r_o_valid || m_axis_tready;
        load_p2       = r_p1_valid && !r_p2_valid;
        load_p1       = r_fin_valid && (!r_p1_valid || load_p2);
        s_axis_tready = !batch_last || !r_fin_valid || load_p1;
        accept        = s_axis_tvalid && s_axis_tready;
        load_fin      = accept && batch_last;
    end

    // slope product, conversion and blend numerator
    always_comb begin
        prod    = PROD_W'(r_fin_sum) * PROD_W'(r_slope) + PROD_W'(phtmc_pkg::Q_HALF);
        term_ok = (r_p1_term <= TERM_W'(r_ofs));
        value   = r_ofs - r_p1_term[OFS_W-1:0];
        val_ok  = term_ok && (value > OFS_W'(r_low)) && (value < OFS_W'(r_high));
        avg_rd  = r_avg[r_p1_probe];
        num     = NUM_W'(avg_rd) * NUM_W'(AVERAGE_WEIGHT - 1) + NUM_W'(value[PH_W-1:0]);
    end

    // divide by the weight and per-probe update
    always_comb begin
        qprod   = QPROD_W'(r_p2_num) * QPROD_W'(RECIP);
        quo     = qprod[RECIP_K +: PH_W];
        new_val = r_p2_avgnz ? quo : r_p2_val;
        fc_rd   = r_fc[r_p2_probe];
        fc_inc  = (fc_rd == phtmc_pkg::FAULT_MAX) ? fc_rd : fc_rd + 1'b1;
        rep_bad = (fc_inc > ERR_W'(ERROR_LIMIT)) ? '0 : r_rep[r_p2_probe];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs       <= phtmc_pkg::RST_PH_OFFSET;
            r_slope     <= phtmc_pkg::RST_PH_SLOPE;
            r_low       <= phtmc_pkg::RST_LOW_LIMIT;
            r_high      <= phtmc_pkg::RST_HIGH_LIMIT;
            r_sidx      <= '0;
            r_gidx      <= '0;
            r_sum       <= '0;
            r_fin_valid <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_avg[i] <= '0;
                r_rep[i] <= '0;
                r_fc[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (phtmc_pkg::t_cfg_idx'(i_cfg_idx))
                    phtmc_pkg::CFG_PH_OFFSET:  r_ofs   <= i_cfg_data[OFS_W-1:0];
                    phtmc_pkg::CFG_PH_SLOPE:   r_slope <= i_cfg_data[SLOPE_W-1:0];
                    phtmc_pkg::CFG_LOW_LIMIT:  r_low   <= i_cfg_data[LIM_W-1:0];
                    phtmc_pkg::CFG_HIGH_LIMIT: r_high  <= i_cfg_data[LIM_W-1:0];
                endcase
            end

            if (accept) begin
                r_sidx <= grp_last ? '0 : r_sidx + 1'b1;
                if (grp_last) begin
                    r_gidx <= batch_last ? '0 : r_gidx + 1'b1;
                end
                r_sum <= batch_last ? '0 : (grp_last ? sum_trim : sum_acc);
            end

            if (load_fin) begin
                r_fin_valid <= 1'b1;
            end else if (load_p1) begin
                r_fin_valid <= 1'b0;
            end

            if (load_p1) begin
                r_p1_valid <= 1'b1;
            end else if (load_p2) begin
                r_p1_valid <= 1'b0;
            end

            if (load_p2) begin
                r_p2_valid <= 1'b1;
            end else if (p2_moves) begin
                r_p2_valid <= 1'b0;
            end

            if (r_p2_valid && p2_moves) begin
                r_o_valid <= 1'b1;
                if (r_p2_ok) begin
                    r_avg[r_p2_probe] <= new_val;
                    r_rep[r_p2_probe] <= new_val;
                    r_fc[r_p2_probe]  <= '0;
                end else begin
                    r_rep[r_p2_probe] <= rep_bad;
                    r_fc[r_p2_probe]  <= fc_inc;
                end
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (load_fin) begin
            r_fin_sum   <= sum_trim;
            r_fin_probe <= s_axis_tuser;
        end
        if (load_p1) begin
            r_p1_term  <= prod[PROD_W-1:phtmc_pkg::Q_FRAC];
            r_p1_probe <= r_fin_probe;
        end
        if (load_p2) begin
            r_p2_num   <= num;
            r_p2_val   <= value[PH_W-1:0];
            r_p2_ok    <= val_ok;
            r_p2_avgnz <= (avg_rd != '0);
            r_p2_probe <= r_p1_probe;
        end
        if (r_p2_valid && p2_moves) begin
            r_o_probe <= r_p2_probe;
            r_o_ok    <= r_p2_ok;
            r_o_ph    <= r_p2_ok ? new_val : rep_bad;
            r_o_err   <= r_p2_ok ? '0 : fc_inc;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_probe;
    assign m_axis_tdata  = {{(phtmc_pkg::TDATA_OUT_W - PH_W - 1 - ERR_W){1'b0}},
                            r_o_err, r_o_ok, r_o_ph};

`ifndef SYNTHESIS
    a_ok_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[phtmc_pkg::OUT_OK_BIT])
        |-> (m_axis_tdata[phtmc_pkg::OUT_ERR_LSB +: ERR_W] == '0))
        else $error("in-range result with nonzero error count");

    a_fault_zeroes_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[phtmc_pkg::OUT_ERR_LSB +: ERR_W] > ERR_W'(ERROR_LIMIT)))
        |-> (m_axis_tdata[phtmc_pkg::OUT_PH_LSB +: PH_W] == '0))
        else $error("faulted probe reports nonzero value");

    a_batch_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fin |-> (!r_fin_valid || load_p1))
        else $error("batch register overwritten");

    a_sidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sidx < SIDX_W'(SAMPLES_PER_GROUP))
        else $error("sample index out of range");

    a_no_p2_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_valid && !p2_moves) |=> (r_p2_valid && $stable(r_p2_num)))
        else $error("blend stage lost while stalled");
`endif

endmodule
